// ===== design/hmm_forward_probability_defines.svh =====
// Assertion macros shared by the forward-probability design files.
`ifndef HMM_FORWARD_PROBABILITY_DEFINES_SVH
`define HMM_FORWARD_PROBABILITY_DEFINES_SVH
`ifndef SYNTHESIS
`define HMM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HMM_ASSERT_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HMM_ASSERT(label, clk, rst_n, prop, msg)
`define HMM_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== design/hmmf_pkg.sv =====
// Shared types, constants and commands for the HMM forward-probability block.
`default_nettype none
package hmmf_pkg;
	localparam int MAX_STATES_D  = 16;
	localparam int MAX_SYMBOLS_D = 256;
	localparam int PROB_BITS_D   = 32;

	localparam logic [2:0] ACT_LOAD_TRANS = 3'd0;
	localparam logic [2:0] ACT_LOAD_EMIT  = 3'd1;
	localparam logic [2:0] ACT_LOAD_INIT  = 3'd2;
	localparam logic [2:0] ACT_OBSERVE    = 3'd3;
	localparam logic [2:0] ACT_QUERY      = 3'd4;

	localparam logic [2:0] ST_ACCEPTED  = 3'd0;
	localparam logic [2:0] ST_VALID     = 3'd1;
	localparam logic [2:0] ST_BAD_STATE = 3'd2;
	localparam logic [2:0] ST_NO_OBS    = 3'd3;
	localparam logic [2:0] ST_BAD_SYM   = 3'd4;
	localparam logic [2:0] ST_BAD_LOAD  = 3'd5;

	localparam logic [0:0] CFG_STATES  = 1'b0;
	localparam logic [0:0] CFG_SYMBOLS = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_acc;    // zero the accumulator
		logic mac;        // acc += trans[s][p] * alpha[p], reads issued this cycle
		logic mac_take;   // product of the previous read is ready to accumulate
		logic rd_emit;    // read emission[s][sym] and the selected base
		logic use_init;   // base is the initial value instead of the accumulator
		logic fin_mul;    // multiply base by emission
		logic wr_next;    // write the finished value into the next-alpha buffer
		logic zero_next;  // write zero into the next-alpha buffer
		logic commit;     // copy next-alpha into alpha
		logic fin_query;  // latch the result field
	} hmmf_cmd_t;
endpackage
`default_nettype wire

// ===== design/hmmf_datapath.sv =====
// Datapath: tables, alpha vectors, shared multiplier and saturating accumulator.
`default_nettype none
`include "hmm_forward_probability_defines.svh"
module hmmf_datapath #(
	parameter int MAX_STATES  = hmmf_pkg::MAX_STATES_D,
	parameter int MAX_SYMBOLS = hmmf_pkg::MAX_SYMBOLS_D,
	parameter int PROB_BITS   = hmmf_pkg::PROB_BITS_D,
	parameter int SW = $clog2(MAX_STATES),
	parameter int YW = $clog2(MAX_SYMBOLS)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire hmmf_pkg::hmmf_cmd_t cmd,
	input  wire [SW-1:0]            s_idx,
	input  wire [SW-1:0]            p_idx,
	input  wire [YW-1:0]            sym_idx,
	input  wire                     wr_trans,
	input  wire                     wr_emit,
	input  wire                     wr_init,
	input  wire [SW-1:0]            ld_row,
	input  wire [YW-1:0]            ld_col,
	input  wire [31:0]              ld_value,
	output logic [31:0]             result
);
	import hmmf_pkg::*;

	localparam int FRAC = PROB_BITS - 1;
	localparam int UP   = (FRAC >= 31) ? FRAC - 31 : 0;
	localparam int DN   = (FRAC < 31) ? 31 - FRAC : 0;
	localparam logic [PROB_BITS-1:0] ONE = PROB_BITS'(1) << FRAC;

	// The transition and emission tables are addressed by concatenated indices, so their depth follows the index widths.
	logic [PROB_BITS-1:0] trans_mem [2**(2*SW)];
	logic [PROB_BITS-1:0] emit_mem  [2**(SW+YW)];
	logic [PROB_BITS-1:0] init_mem  [MAX_STATES];
	logic [PROB_BITS-1:0] alpha_q   [MAX_STATES];
	logic [PROB_BITS-1:0] next_q    [MAX_STATES];

	logic [PROB_BITS-1:0] ld_fx;
	logic [PROB_BITS+31:0] ld_wide;
	logic [PROB_BITS-1:0] op_a_q, op_b_q, acc_q, emit_q, base_q;
	logic [2*PROB_BITS-1:0] prod_s1;
	logic [2*PROB_BITS-1:0] prod_shift;
	logic [PROB_BITS-1:0] prod_sat;
	logic [PROB_BITS:0] sum;
	logic mac_d_q, mac_d2_q, fin_d_q, fin_d2_q;
	logic [PROB_BITS-1:0] res_int;

	always_comb begin
		ld_wide = ((PROB_BITS+32)'(ld_value) << UP) >> DN;
		ld_fx = (ld_wide > (PROB_BITS+32)'(ONE)) ? ONE : PROB_BITS'(ld_wide);
	end

	always_ff @(posedge clk) begin
		if (wr_trans) trans_mem[{ld_row, ld_col[SW-1:0]}] <= ld_fx;
		if (wr_emit) emit_mem[{ld_row, ld_col}] <= ld_fx;
		if (wr_init) init_mem[ld_row] <= ld_fx;
		if (cmd.mac) begin
			op_a_q <= trans_mem[{s_idx, p_idx}];
			op_b_q <= alpha_q[p_idx];
		end
		if (cmd.rd_emit) begin
			emit_q <= emit_mem[{s_idx, sym_idx}];
			base_q <= cmd.use_init ? init_mem[s_idx] : acc_q;
		end
	end

	// Multiplier stage, operands come from either the MAC reads or the final multiply.
	logic [PROB_BITS-1:0] mul_a, mul_b;
	assign mul_a = fin_d_q ? base_q : op_a_q;
	assign mul_b = fin_d_q ? emit_q : op_b_q;

	always_ff @(posedge clk) prod_s1 <= mul_a * mul_b;

	assign prod_shift = prod_s1 >> FRAC;
	assign prod_sat = (prod_shift > (2*PROB_BITS)'(ONE)) ? ONE : PROB_BITS'(prod_shift);
	assign sum = {1'b0, acc_q} + {1'b0, prod_sat};
	assign res_int = prod_sat;

	// The next-alpha buffer is emptied at each commit, so states outside the model read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_d_q  <= 1'b0;
			mac_d2_q <= 1'b0;
			fin_d_q  <= 1'b0;
			fin_d2_q <= 1'b0;
			acc_q    <= '0;
			for (int i = 0; i < MAX_STATES; i++) begin
				alpha_q[i] <= '0;
				next_q[i]  <= '0;
			end
		end else begin
			mac_d_q  <= cmd.mac;
			mac_d2_q <= mac_d_q;
			fin_d_q  <= cmd.rd_emit;
			fin_d2_q <= fin_d_q;
			if (cmd.clr_acc) acc_q <= '0;
			else if (cmd.mac_take)
				acc_q <= (sum > (PROB_BITS+1)'(ONE)) ? ONE : PROB_BITS'(sum);
			if (cmd.commit) begin
				for (int i = 0; i < MAX_STATES; i++) begin
					alpha_q[i] <= next_q[i];
					next_q[i]  <= '0;
				end
			end else if (cmd.wr_next) next_q[s_idx] <= res_int;
			else if (cmd.zero_next) next_q[s_idx] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_query) result <= 32'(({32'b0, res_int} >> UP) << DN);
	end

	`HMM_ASSERT(a_take_follows_mac, clk, arst_n, cmd.mac_take |-> mac_d2_q, "accumulate without a MAC read")
	`HMM_ASSERT(a_fin_timing, clk, arst_n, (cmd.wr_next || cmd.fin_query) |-> fin_d2_q, "final multiply result used too early")
	`HMM_ASSERT(a_acc_bounded, clk, arst_n, acc_q <= ONE, "accumulator above one")
endmodule
`default_nettype wire

// ===== design/hmmf_ctrl.sv =====
// Controller: decodes items, checks indices and sequences the forward recursion.
`default_nettype none
`include "hmm_forward_probability_defines.svh"
module hmmf_ctrl #(
	parameter int MAX_STATES  = hmmf_pkg::MAX_STATES_D,
	parameter int MAX_SYMBOLS = hmmf_pkg::MAX_SYMBOLS_D,
	parameter int SW = $clog2(MAX_STATES),
	parameter int YW = $clog2(MAX_SYMBOLS)
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire [2:0]                 action,
	input  wire [3:0]                 row_index,
	input  wire [7:0]                 column_index,
	input  wire [7:0]                 symbol,
	input  wire [3:0]                 hidden_state,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire                       cfg_index,
	input  wire [8:0]                 cfg_data,
	output hmmf_pkg::hmmf_cmd_t       cmd,
	output logic [SW-1:0]             s_idx,
	output logic [SW-1:0]             p_idx,
	output logic [YW-1:0]             sym_idx,
	output logic                      wr_trans,
	output logic                      wr_emit,
	output logic                      wr_init,
	output logic [SW-1:0]             ld_row,
	output logic [YW-1:0]             ld_col,
	output logic                      out_valid,
	input  wire                       out_ready,
	output logic [2:0]                status,
	output logic                      prob_sel
);
	import hmmf_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_EMIT, S_WAIT, S_STORE, S_DONE} state_t;
	state_t state_q;

	logic [4:0] states_q;
	logic [8:0] symbols_q;
	logic [SW:0] ns;
	logic [YW:0] nsym;
	logic seen_q, query_q, first_q;
	logic [SW-1:0] s_q, p_q;
	logic [YW-1:0] sym_q;
	logic [1:0] drain_q;
	logic [1:0] mac_pipe_q;
	logic accept, busy_out;
	logic [2:0] chk;
	logic row_ok, col_st_ok, col_sym_ok, sym_ok, hs_ok;

	always_comb begin
		if (states_q == 5'd0) ns = (SW+1)'(1);
		else if (32'(states_q) > MAX_STATES) ns = (SW+1)'(MAX_STATES);
		else ns = (SW+1)'(states_q);
		if (symbols_q == 9'd0) nsym = (YW+1)'(1);
		else if (32'(symbols_q) > MAX_SYMBOLS) nsym = (YW+1)'(MAX_SYMBOLS);
		else nsym = (YW+1)'(symbols_q);
	end

	assign row_ok     = 32'(row_index) < 32'(ns);
	assign col_st_ok  = 32'(column_index) < 32'(ns);
	assign col_sym_ok = 32'(column_index) < 32'(nsym);
	assign sym_ok     = 32'(symbol) < 32'(nsym);
	assign hs_ok      = 32'(hidden_state) < 32'(ns);

	// A new item may enter in the cycle the pending result is taken.
	assign in_ready  = (state_q == S_IDLE) && (!out_valid || out_ready);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign busy_out  = out_valid && !out_ready;

	always_comb begin
		chk = ST_ACCEPTED;
		unique case (action)
			ACT_LOAD_TRANS: if (!row_ok || !col_st_ok) chk = ST_BAD_LOAD;
			ACT_LOAD_EMIT:  if (!row_ok || !col_sym_ok) chk = ST_BAD_LOAD;
			ACT_LOAD_INIT:  if (!row_ok) chk = ST_BAD_LOAD;
			ACT_OBSERVE:    if (!sym_ok) chk = ST_BAD_SYM;
			ACT_QUERY: begin
				if (!hs_ok) chk = ST_BAD_STATE;
				else if (!seen_q) chk = ST_NO_OBS;
				else if (!sym_ok) chk = ST_BAD_SYM;
			end
			default: chk = ST_ACCEPTED;
		endcase
	end

	assign ld_row   = SW'(row_index);
	assign ld_col   = YW'(column_index);
	assign wr_trans = accept && action == ACT_LOAD_TRANS && chk == ST_ACCEPTED;
	assign wr_emit  = accept && action == ACT_LOAD_EMIT && chk == ST_ACCEPTED;
	assign wr_init  = accept && action == ACT_LOAD_INIT && chk == ST_ACCEPTED;
	assign s_idx    = s_q;
	assign p_idx    = p_q;
	assign sym_idx  = sym_q;

	always_comb begin
		cmd = '0;
		cmd.clr_acc   = (state_q == S_IDLE) || (state_q == S_STORE);
		cmd.mac       = state_q == S_MAC;
		cmd.mac_take  = mac_pipe_q[1];
		cmd.rd_emit   = state_q == S_EMIT;
		cmd.use_init  = first_q;
		cmd.wr_next   = state_q == S_STORE && !query_q;
		cmd.zero_next = 1'b0;
		cmd.fin_query = state_q == S_STORE && query_q;
		cmd.commit    = state_q == S_DONE && !query_q;
	end

	// MAC reads and products are registered; mac_pipe_q delays mac_take to match them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			states_q   <= 5'd16;
			symbols_q  <= 9'd256;
			seen_q     <= 1'b0;
			query_q    <= 1'b0;
			first_q    <= 1'b0;
			s_q        <= '0;
			p_q        <= '0;
			sym_q      <= '0;
			drain_q    <= '0;
			mac_pipe_q <= '0;
			out_valid  <= 1'b0;
			status     <= ST_ACCEPTED;
			prob_sel   <= 1'b0;
		end else begin
			mac_pipe_q <= {mac_pipe_q[0], state_q == S_MAC};
			if (cfg_valid) begin
				if (cfg_index == CFG_STATES) states_q <= cfg_data[4:0];
				else symbols_q <= cfg_data;
			end
			if (out_valid && out_ready && !accept) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					sym_q   <= YW'(symbol);
					s_q     <= (action == ACT_QUERY) ? SW'(hidden_state) : '0;
					p_q     <= '0;
					first_q <= !seen_q;
					if ((action == ACT_OBSERVE || action == ACT_QUERY) && chk == ST_ACCEPTED) begin
						query_q   <= action == ACT_QUERY;
						out_valid <= 1'b0;
						state_q   <= seen_q ? S_MAC : S_EMIT;
					end else begin
						out_valid <= 1'b1;
						status    <= chk;
						prob_sel  <= 1'b0;
					end
				end
				S_MAC: begin
					if (32'(p_q) == 32'(ns) - 1) begin
						state_q <= S_DRAIN;
						drain_q <= 2'd0;
					end else p_q <= p_q + SW'(1);
				end
				S_DRAIN: begin
					if (drain_q == 2'd1) state_q <= S_EMIT;
					drain_q <= drain_q + 2'd1;
				end
				S_EMIT:  state_q <= S_WAIT;
				S_WAIT:  state_q <= S_STORE;
				S_STORE: begin
					p_q <= '0;
					if (query_q || 32'(s_q) == 32'(ns) - 1) state_q <= S_DONE;
					else begin
						s_q     <= s_q + SW'(1);
						state_q <= first_q ? S_EMIT : S_MAC;
					end
				end
				S_DONE: if (!busy_out) begin
					seen_q    <= !query_q;
					out_valid <= 1'b1;
					status    <= query_q ? ST_VALID : ST_ACCEPTED;
					prob_sel  <= query_q;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HMM_ASSERT(a_no_accept_busy, clk, arst_n, (state_q != S_IDLE) |-> !in_ready, "item accepted during a recursion")
	`HMM_ASSERT(a_p_in_range, clk, arst_n, (state_q == S_MAC) |-> (32'(p_q) < 32'(ns)), "previous-state counter out of range")
	`HMM_ASSERT(a_done_result, clk, arst_n, (state_q == S_DONE && !busy_out) |=> out_valid, "recursion finished without a result")
endmodule
`default_nettype wire

// ===== design/hmm_forward_probability.sv =====
// Top level of the HMM forward-probability block.
// Usage:
//   Items enter on the in_valid/in_ready channel and each gives exactly one
//   result transaction on out_valid/out_ready (status, probability, underflow).
//   Loads and rejected items finish in S_IDLE; their result is registered at
//   acceptance and appears in the following cycle. An observation runs
//   through one shared multiplier: per state N multiply-accumulates plus a
//   drain and an emission multiply for N states in use, the first observation
//   of a sequence doing only the emission multiply. A query runs the same
//   steps for the one state it names. Registers are to be written on
//   cfg_valid/cfg_ready only while the block is idle, which it does not enforce.
//   Reset clears alpha, the seen-observation flag and the registers (16 states,
//   256 symbols); table contents are undefined until loaded.
//   While the receiver stalls the result holds and no new item is taken; a
//   new item can enter in the cycle the pending result is read.
`default_nettype none
module hmm_forward_probability #(
	parameter int MAX_STATES  = hmmf_pkg::MAX_STATES_D,
	parameter int MAX_SYMBOLS = hmmf_pkg::MAX_SYMBOLS_D,
	parameter int PROB_BITS   = hmmf_pkg::PROB_BITS_D
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [2:0]  action,
	input  wire [3:0]  row_index,
	input  wire [7:0]  column_index,
	input  wire [31:0] load_value,
	input  wire [7:0]  symbol,
	input  wire [3:0]  hidden_state,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        cfg_index,
	input  wire [8:0]  cfg_data,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [2:0] status,
	output logic [31:0] probability,
	output logic       underflow
);
	import hmmf_pkg::*;

	localparam int SW = $clog2(MAX_STATES);
	localparam int YW = $clog2(MAX_SYMBOLS);

	hmmf_cmd_t cmd;
	logic [SW-1:0] s_idx, p_idx, ld_row;
	logic [YW-1:0] sym_idx, ld_col;
	logic wr_trans, wr_emit, wr_init, prob_sel;
	logic [31:0] result;

	hmmf_ctrl #(.MAX_STATES(MAX_STATES), .MAX_SYMBOLS(MAX_SYMBOLS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .action, .row_index, .column_index,
		.symbol, .hidden_state, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.cmd, .s_idx, .p_idx, .sym_idx, .wr_trans, .wr_emit, .wr_init,
		.ld_row, .ld_col, .out_valid, .out_ready, .status, .prob_sel
	);

	hmmf_datapath #(.MAX_STATES(MAX_STATES), .MAX_SYMBOLS(MAX_SYMBOLS),
		.PROB_BITS(PROB_BITS)) u_dp (
		.clk, .arst_n, .cmd, .s_idx, .p_idx, .sym_idx, .wr_trans, .wr_emit,
		.wr_init, .ld_row, .ld_col, .ld_value(load_value), .result
	);

	assign probability = prob_sel ? result : 32'd0;
	assign underflow   = prob_sel && (result == 32'd0);
endmodule
`default_nettype wire
